FILE: design/biou_pkg.sv
package biou_pkg;

   localparam int COORD_BITS = 16;
   localparam int FRAC_BITS  = 16;

   localparam int EDGE_W  = COORD_BITS + 1;
   localparam int AREA_W  = 2 * COORD_BITS;
   localparam int DEN_W   = AREA_W + 1;
   localparam int REM_W   = AREA_W + 2;
   localparam int RATIO_W = FRAC_BITS + 1;
   localparam int NUM_CELLS = FRAC_BITS + 1;

   typedef struct packed {
      logic [COORD_BITS-1:0] ref_left;
      logic [COORD_BITS-1:0] ref_top;
      logic [COORD_BITS-1:0] ref_width;
      logic [COORD_BITS-1:0] ref_height;
      logic [COORD_BITS-1:0] det_left;
      logic [COORD_BITS-1:0] det_top;
      logic [COORD_BITS-1:0] det_width;
      logic [COORD_BITS-1:0] det_height;
      logic                  crowd_mode;
   } req_payload_type;

   typedef struct packed {
      logic [RATIO_W-1:0] overlap_ratio;
      logic [AREA_W-1:0]  overlap_area;
      logic               zero_denominator;
   } rsp_payload_type;

   typedef struct packed {
      logic               valid;
      logic [DEN_W-1:0]   den;
      logic [REM_W-1:0]   rem;
      logic [RATIO_W-1:0] quo;
      logic [AREA_W-1:0]  area;
      logic               zero;
   } div_stage_type;

endpackage

FILE: design/biou_front.sv
module biou_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     in_valid,
   input  biou_pkg::req_payload_type in_data,
   output biou_pkg::div_stage_type  out_stage
);

   localparam int CB = biou_pkg::COORD_BITS;
   localparam int EW = biou_pkg::EDGE_W;
   localparam int AW = biou_pkg::AREA_W;
   localparam int DW = biou_pkg::DEN_W;
   localparam int RW = biou_pkg::REM_W;

   // stage a: axis overlaps
   logic          a_valid_ff;
   logic [CB-1:0] a_iw_ff, a_ih_ff, a_rw_ff, a_rh_ff, a_dw_ff, a_dh_ff;
   logic          a_crowd_ff;
   logic [CB-1:0] a_iw_in, a_ih_in;

   // stage b: areas
   logic          b_valid_ff;
   logic [AW-1:0] b_inter_ff, b_ref_ff, b_det_ff;
   logic          b_crowd_ff;

   // stage c: divisor
   biou_pkg::div_stage_type c_ff, c_in;

   function automatic logic [CB-1:0] axis_overlap(
      input logic [CB-1:0] a0, input logic [CB-1:0] alen,
      input logic [CB-1:0] b0, input logic [CB-1:0] blen);
      logic [EW-1:0] lo, hi, ae, be, diff;
      lo = (a0 > b0) ? EW'(a0) : EW'(b0);
      ae = EW'(a0) + EW'(alen);
      be = EW'(b0) + EW'(blen);
      hi = (ae < be) ? ae : be;
      diff = hi - lo;
      return (hi > lo) ? diff[CB-1:0] : '0;
   endfunction

   always_comb begin
      a_iw_in = axis_overlap(in_data.ref_left, in_data.ref_width,
                             in_data.det_left, in_data.det_width);
      a_ih_in = axis_overlap(in_data.ref_top, in_data.ref_height,
                             in_data.det_top, in_data.det_height);
   end

   always_comb begin
      logic [DW-1:0] union_area;
      union_area = DW'(b_ref_ff) + DW'(b_det_ff) - DW'(b_inter_ff);
      c_in.valid = b_valid_ff;
      c_in.den   = b_crowd_ff ? DW'(b_det_ff) : union_area;
      c_in.zero  = b_crowd_ff ? (b_det_ff == '0) : (union_area == '0);
      c_in.rem   = RW'(b_inter_ff);
      c_in.quo   = '0;
      c_in.area  = b_inter_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_ff.valid <= 1'b0;
      end else if (en) begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
         c_ff.valid <= c_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_iw_ff    <= a_iw_in;
         a_ih_ff    <= a_ih_in;
         a_rw_ff    <= in_data.ref_width;
         a_rh_ff    <= in_data.ref_height;
         a_dw_ff    <= in_data.det_width;
         a_dh_ff    <= in_data.det_height;
         a_crowd_ff <= in_data.crowd_mode;
         b_inter_ff <= AW'(a_iw_ff) * AW'(a_ih_ff);
         b_ref_ff   <= AW'(a_rw_ff) * AW'(a_rh_ff);
         b_det_ff   <= AW'(a_dw_ff) * AW'(a_dh_ff);
         b_crowd_ff <= a_crowd_ff;
         c_ff.den   <= c_in.den;
         c_ff.rem   <= c_in.rem;
         c_ff.quo   <= c_in.quo;
         c_ff.area  <= c_in.area;
         c_ff.zero  <= c_in.zero;
      end
   end

   assign out_stage = c_ff;

endmodule

FILE: design/biou_div_cell.sv
module biou_div_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  biou_pkg::div_stage_type in_stage,
   output biou_pkg::div_stage_type out_stage
);

   localparam int RW = biou_pkg::REM_W;
   localparam int QW = biou_pkg::RATIO_W;

   biou_pkg::div_stage_type stage_ff, stage_in;

   always_comb begin
      logic          take;
      logic [RW-1:0] rem_next;
      take     = in_stage.rem >= RW'(in_stage.den);
      rem_next = take ? (in_stage.rem - RW'(in_stage.den)) : in_stage.rem;
      stage_in       = in_stage;
      stage_in.rem   = {rem_next[RW-2:0], 1'b0};
      stage_in.quo   = {in_stage.quo[QW-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (en) begin
         stage_ff.valid <= stage_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         stage_ff.den  <= stage_in.den;
         stage_ff.rem  <= stage_in.rem;
         stage_ff.quo  <= stage_in.quo;
         stage_ff.area <= stage_in.area;
         stage_ff.zero <= stage_in.zero;
      end
   end

   assign out_stage = stage_ff;

endmodule

FILE: design/box_iou_with_crowd_mode.sv
// Box intersection over union, one box pair per clock. The clamped overlap
// area goes over the union area, or over the detected area in crowd mode,
// as a truncated fraction with 16 fraction bits (65536 is 1.0). A zero
// divisor gives ratio 0 with zero_denominator set. The path is registered in
// three front stages (overlap, area multipliers, divisor), one restoring
// division cell per quotient bit (17), and the output register. A new
// request is taken every cycle unless the output register is full and stalled.
module box_iou_with_crowd_mode (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  biou_pkg::req_payload_type req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output biou_pkg::rsp_payload_type rsp_data
);

   localparam int NC = biou_pkg::NUM_CELLS;

   logic                      en;
   logic                      rsp_valid_ff;
   biou_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;
   biou_pkg::div_stage_type   chain [0:NC];

   assign en = !rsp_valid_ff || rsp_ready;

   biou_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .out_stage (chain[0])
   );

   for (genvar i = 0; i < NC; i++) begin : g_cell
      biou_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_stage  (chain[i]),
         .out_stage (chain[i+1])
      );
   end

   always_comb begin
      rsp_data_in.overlap_ratio    = chain[NC].zero ? '0 : chain[NC].quo;
      rsp_data_in.overlap_area     = chain[NC].area;
      rsp_data_in.zero_denominator = chain[NC].zero;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= chain[NC].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign req_ready = en;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: design/biou_checker.sv
module biou_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input biou_pkg::rsp_payload_type rsp_data
);

   localparam logic [biou_pkg::RATIO_W-1:0] ONE =
      biou_pkg::RATIO_W'(1) << biou_pkg::FRAC_BITS;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while output stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.zero_denominator |->
         rsp_data.overlap_ratio == '0 && rsp_data.overlap_area == '0)
      else $error("zero divisor with nonzero result");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.overlap_ratio <= ONE)
      else $error("ratio above one");

   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind box_iou_with_crowd_mode biou_checker u_biou_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
